[hw/rtl/lru_key_value_cache_assert.svh]
// Assertion macros used by the cache entry store (lkv_store).
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define LKV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication: when the trigger holds, the consequence must hold too.
`define LKV_ASSERT_IMPL(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

[hw/rtl/lkv_pkg.sv]
// Package with the constants, codes and request/result types of the LRU cache.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int CAPX_W     = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } lkv_op_t;

  typedef struct packed {
    lkv_op_t                       op;
    logic signed [KEY_BITS-1:0]    key;
    logic signed [VALUE_BITS-1:0]  value_in;
  } lkv_req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [VALUE_BITS-1:0]  value_out;
    logic                          evicted;
    logic signed [KEY_BITS-1:0]    evicted_key;
  } lkv_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/lkv_channels.sv]
// Handshake channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface lkv_req_if import lkv_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [KEY_BITS-1:0]   key;
  logic signed [VALUE_BITS-1:0] value_in;

  modport source (output valid, output op, output key, output value_in, input ready);
  modport sink (input valid, input op, input key, input value_in, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] value_out;
  logic                         evicted;
  logic signed [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output value_out, output evicted,
                  output evicted_key, input ready);
  modport sink (input valid, input hit, input value_out, input evicted,
                input evicted_key, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] cap_in_use;

  modport source (output valid, output cap_in_use, input ready);
  modport sink (input valid, input cap_in_use, output ready);
endinterface

`default_nettype wire

[hw/rtl/lru_key_value_cache.sv]
// A request goes from the input register through the store into the result register.
// Throughput: one request per cycle while the consumer takes results; the key match and
// rank update over all entries are combinational between input and result registers.
// Reset (synchronous, rst_n low): clears all valid marks and occupancy, sets each
// entry's recency rank to its index and the capacity register to 16; keys and
// values are not cleared, and requests are accepted as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache import lkv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  lkv_req_if.sink   in_chan,
  lkv_rsp_if.source out_chan,
  lkv_cfg_if.sink   cfg_chan
);

  lkv_req_t req_in;
  lkv_req_t held_req;
  lkv_rsp_t rsp_comb;
  lkv_rsp_t rsp_out;
  logic     held_valid;
  logic     can_load;
  logic     fire;

  // Gather the request fields.
  assign req_in = '{op: lkv_op_t'(in_chan.op), key: in_chan.key, value_in: in_chan.value_in};

  // A held request is processed when the result register can take its result.
  assign fire = held_valid && can_load;

  // The capacity register is always writable.
  assign cfg_chan.ready = 1'b1;

  lkv_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_chan.valid),
    .req_ready  (in_chan.ready),
    .req_in     (req_in),
    .advance    (fire),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  lkv_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_chan.valid),
    .cfg_data (cfg_chan.cap_in_use),
    .fire     (fire),
    .req      (held_req),
    .rsp      (rsp_comb)
  );

  lkv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .rsp_in    (rsp_comb),
    .rsp_ready (out_chan.ready),
    .rsp_valid (out_chan.valid),
    .can_load  (can_load),
    .rsp_out   (rsp_out)
  );

  // Drive the result fields.
  assign out_chan.hit         = rsp_out.hit;
  assign out_chan.value_out   = rsp_out.value_out;
  assign out_chan.evicted     = rsp_out.evicted;
  assign out_chan.evicted_key = rsp_out.evicted_key;

endmodule
`default_nettype wire

[hw/rtl/lkv_in_stage.sv]
// Input register that holds one accepted request until the store processes it.
`timescale 1ns / 1ps
`default_nettype none
module lkv_in_stage import lkv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire lkv_req_t req_in,
  input  wire logic     advance,
  output logic          held_valid,
  output lkv_req_t      held_req
);

  logic     valid_r;
  logic     valid_nxt;
  lkv_req_t req_r;

  // A new request may enter when the stage is empty or drains this cycle.
  assign req_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (req_ready) begin
      valid_nxt = req_valid;
    end
  end

  // Occupancy flag of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Request payload, loaded on acceptance.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req_in;
    end
  end

  assign held_valid = valid_r;
  assign held_req   = req_r;

endmodule
`default_nettype wire

[hw/rtl/lkv_store.sv]
// Entry store with parallel key match, recency ranks, occupancy and capacity register.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_assert.svh"
module lkv_store import lkv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             fire,
  input  wire lkv_req_t         req,
  output lkv_rsp_t              rsp
);

  logic [KEY_BITS-1:0]   key_r   [ENTRIES];
  logic [VALUE_BITS-1:0] value_r [ENTRIES];
  logic [ENTRIES-1:0]    valid_r;
  logic [ENTRIES-1:0]    valid_nxt;
  logic [IDX_W-1:0]      rank_r   [ENTRIES];
  logic [IDX_W-1:0]      rank_nxt [ENTRIES];
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      occ_nxt;
  logic [CAP_W-1:0]      cap_r;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    victim_oh;
  logic                  hit_any;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      victim_idx;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      touch_idx;
  logic [IDX_W-1:0]      touch_rank;
  logic [CAPX_W-1:0]     cap_ext;
  logic [CAPX_W-1:0]     eff_cap;
  logic                  need_evict;
  logic                  is_put;
  logic                  do_touch;
  logic                  do_write;
  logic                  do_evict;

  // Key match against every valid entry, and the lowest-indexed hit.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req.key);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    hit_any = |match;
  end

  // The valid entries always hold ranks 0 to occupancy-1, so the least
  // recent one is the valid entry whose rank is occupancy minus one.
  always_comb begin
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = valid_r[i] && (OCC_W'(rank_r[i]) == (occ_r - OCC_W'(1)));
      if (victim_oh[i]) begin
        victim_idx = IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Capacity in use, clamped to the range one to the number of entries.
  always_comb begin
    cap_ext = CAPX_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CAPX_W'(1);
    end else if (cap_ext > CAPX_W'(ENTRIES)) begin
      eff_cap = CAPX_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    need_evict = CAPX_W'(occ_r) >= eff_cap;
  end

  // Decide which entry the request touches and build the result.
  always_comb begin
    is_put   = (req.op == OP_PUT);
    do_evict = is_put && !hit_any && need_evict;
    do_touch = fire && (hit_any || is_put);
    do_write = fire && is_put;
    if (hit_any) begin
      touch_idx = hit_idx;
    end else if (need_evict) begin
      touch_idx = victim_idx;
    end else begin
      touch_idx = free_idx;
    end
    touch_rank = rank_r[touch_idx];

    rsp.hit         = hit_any;
    rsp.value_out   = (hit_any && !is_put) ? value_r[hit_idx] : '0;
    rsp.evicted     = do_evict;
    rsp.evicted_key = do_evict ? key_r[victim_idx] : '0;
  end

  // Next ranks, valid bits and occupancy.
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (IDX_W'(i) == touch_idx) begin
          rank_nxt[i] = '0;
        end else if (rank_r[i] < touch_rank) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
    end
    if (do_write) begin
      valid_nxt[touch_idx] = 1'b1;
      if (!hit_any && !need_evict) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  // Control state: valid bits, ranks, occupancy and the capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      rank_r  <= rank_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Key and value storage, written by a put.
  always_ff @(posedge clk) begin
    if (do_write) begin
      key_r[touch_idx]   <= req.key;
      value_r[touch_idx] <= req.value_in;
    end
  end

  // Checks on the bookkeeping.
  `LKV_ASSERT(a_occ_bound, clk, rst_n, occ_r <= OCC_W'(ENTRIES), "occupancy above entry count")
  `LKV_ASSERT(a_occ_count, clk, rst_n, $countones(valid_r) == int'(occ_r), "occupancy count mismatch")
  `LKV_ASSERT(a_match_one, clk, rst_n, $onehot0(match), "key present in more than one entry")
  `LKV_ASSERT_IMPL(a_victim_found, clk, rst_n, fire && do_evict, $onehot(victim_oh), "no single victim")
  `LKV_ASSERT_IMPL(a_free_slot, clk, rst_n, fire && is_put && !hit_any && !need_evict, !valid_r[free_idx], "no free entry for insert")

endmodule
`default_nettype wire

[hw/rtl/lkv_out_stage.sv]
// Result register that holds one result until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module lkv_out_stage import lkv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire lkv_rsp_t rsp_in,
  input  wire logic     rsp_ready,
  output logic          rsp_valid,
  output logic          can_load,
  output lkv_rsp_t      rsp_out
);

  logic     valid_r;
  logic     valid_nxt;
  lkv_rsp_t rsp_r;

  // The register can take a result when empty or when its result leaves now.
  assign can_load = !valid_r || rsp_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (rsp_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp_in;
    end
  end

  assign rsp_valid = valid_r;
  assign rsp_out   = rsp_r;

endmodule
`default_nettype wire
